// ----- rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache table.
// Request and response beats, controller commands and status, FSM states.
// No dependencies.
package lfu_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } lfu_req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } lfu_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DECIDE,
        ST_SWEEP,
        ST_SWEEP_TAIL,
        ST_RESP
    } lfu_state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic scan_rd;
        logic decide;
        logic sweep_rd;
        logic respond;
    } lfu_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;
        logic need_sweep;
        logic rsp_free;
    } lfu_stat_t;

endpackage

// ----- rtl/lfu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lfu_ctrl.sv -----
// Controller FSM for the LFU cache table: sequences the scan pass, the
// decision step, the rank-update pass and the response. Uses lfu_pkg.
module lfu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  lfu_pkg::lfu_stat_t stat,
    output lfu_pkg::lfu_ctrl_t ctrl
);
    import lfu_pkg::*;

    lfu_state_t state_reg;
    lfu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctrl.start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan_rd = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_SCAN_TAIL;
                end
            end
            // last read word lands here
            ST_SCAN_TAIL:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                ctrl.decide = 1'b1;
                state_next  = stat.need_sweep ? ST_SWEEP : ST_RESP;
            end
            ST_SWEEP:
            begin
                ctrl.sweep_rd = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_SWEEP_TAIL;
                end
            end
            ST_SWEEP_TAIL:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.rsp_free)
                begin
                    ctrl.respond = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lfu_datapath.sv -----
// Datapath for the LFU cache table: entry RAM, valid bits, scan accumulators,
// rank-update write-back, capacity register and response register.
// Uses lfu_pkg and lfu_ram.
module lfu_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfu_pkg::lfu_ctrl_t          ctrl,
    output lfu_pkg::lfu_stat_t          stat,
    input  lfu_pkg::lfu_req_t           req,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]   cfg_capacity,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output lfu_pkg::lfu_rsp_t           rsp
);
    import lfu_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int W  = 96 + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    // control state
    logic [CAP_W-1:0]       cap_reg;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   pend_scan_reg, pend_sweep_reg;
    logic [IW-1:0]          pidx_reg;
    logic                   rsp_valid_reg, rsp_valid_next;

    // payload
    lfu_req_t      req_reg, req_next;
    logic [CW-1:0] used_reg, used_next;
    logic          found_reg, found_next;
    logic [IW-1:0] found_idx_reg, found_idx_next;
    logic [31:0]   found_data_reg, found_data_next;
    logic [IW-1:0] found_rank_reg, found_rank_next;
    logic          vic_ok_reg, vic_ok_next;
    logic [IW-1:0] vic_idx_reg, vic_idx_next;
    logic [31:0]   vic_cnt_reg, vic_cnt_next;
    logic [IW-1:0] vic_rank_reg, vic_rank_next;
    logic          free_ok_reg, free_ok_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] thr_reg, thr_next;
    logic          inc_all_reg, inc_all_next;
    lfu_rsp_t      rsp_reg, rsp_next;

    logic [W-1:0]  rdata;
    logic [W-1:0]  wdata;
    logic          we;
    logic [31:0]   w_key, w_data, w_cnt;
    logic [IW-1:0] w_rank;
    logic [CW-1:0] cap_eff;
    logic          is_put;
    logic          evict;
    logic          need_sweep;
    logic [31:0]   new_data, new_cnt;

    lfu_ram #(
        .WIDTH (W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (pidx_reg),
        .wdata (wdata),
        .re    (ctrl.scan_rd | ctrl.sweep_rd),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign w_key  = rdata[W-1 -: 32];
    assign w_data = rdata[W-33 -: 32];
    assign w_cnt  = rdata[W-65 -: 32];
    assign w_rank = rdata[IW-1:0];

    assign cfg_ready = 1'b1;
    assign is_put    = (req_reg.cmd == CMD_PUT);

    always_comb
    begin
        if (32'(cap_reg) > 32'(MAX_ENTRIES))
        begin
            cap_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign evict      = !found_reg && ((used_reg >= cap_eff) || !free_ok_reg);
    assign need_sweep = (found_reg && !is_put) || (is_put && (cap_eff != '0));

    assign stat.idx_last   = (idx_reg == LAST_IDX);
    assign stat.need_sweep = need_sweep;
    assign stat.rsp_free   = !rsp_valid_reg || rsp_ready;

    assign new_data = is_put ? $unsigned(req_reg.value) : w_data;
    assign new_cnt  = !found_reg ? 32'd1 :
                      ((w_cnt == 32'hFFFF_FFFF) ? w_cnt : w_cnt + 32'd1);

    // scan accumulation and decision
    always_comb
    begin
        req_next        = req_reg;
        used_next       = used_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_data_next = found_data_reg;
        found_rank_next = found_rank_reg;
        vic_ok_next     = vic_ok_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        free_ok_next    = free_ok_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        thr_next        = thr_reg;
        inc_all_next    = inc_all_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;

        if (ctrl.start)
        begin
            req_next     = req;
            used_next    = '0;
            found_next   = 1'b0;
            vic_ok_next  = 1'b0;
            free_ok_next = 1'b0;
            idx_next     = '0;
        end

        if (ctrl.scan_rd || ctrl.sweep_rd)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (pend_scan_reg)
        begin
            if (valid_reg[pidx_reg])
            begin
                used_next = used_reg + 1'b1;
                if (!found_reg && (w_key == $unsigned(req_reg.key)))
                begin
                    found_next      = 1'b1;
                    found_idx_next  = pidx_reg;
                    found_data_next = w_data;
                    found_rank_next = w_rank;
                end
                // lowest count wins; on equal counts the oldest rank
                if (!vic_ok_reg || (w_cnt < vic_cnt_reg) ||
                    ((w_cnt == vic_cnt_reg) && (w_rank > vic_rank_reg)))
                begin
                    vic_ok_next   = 1'b1;
                    vic_idx_next  = pidx_reg;
                    vic_cnt_next  = w_cnt;
                    vic_rank_next = w_rank;
                end
            end
            else if (!free_ok_reg)
            begin
                free_ok_next  = 1'b1;
                free_idx_next = pidx_reg;
            end
        end

        if (ctrl.decide)
        begin
            idx_next = '0;
            if (found_reg)
            begin
                slot_next = found_idx_reg;
                thr_next  = found_rank_reg;
            end
            else if (evict)
            begin
                slot_next = vic_idx_reg;
                thr_next  = vic_rank_reg;
            end
            else
            begin
                slot_next = free_idx_reg;
                thr_next  = vic_rank_reg;
            end
            // a fresh insert into a free slot pushes every live entry back
            inc_all_next = !found_reg && !evict;
            if (need_sweep && !found_reg && !evict)
            begin
                valid_next[free_idx_reg] = 1'b1;
            end
        end
    end

    // rank-update write-back; an evicted victim slot is reused in place
    always_comb
    begin
        we    = 1'b0;
        wdata = rdata;
        if (pend_sweep_reg)
        begin
            if (pidx_reg == slot_reg)
            begin
                we    = 1'b1;
                wdata = {$unsigned(req_reg.key), new_data, new_cnt, IW'(0)};
            end
            else if (valid_reg[pidx_reg] && (inc_all_reg || (w_rank < thr_reg)))
            begin
                we    = 1'b1;
                wdata = {w_key, w_data, w_cnt, w_rank + 1'b1};
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (ctrl.respond)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.hit   = found_reg;
            rsp_next.read_value = (found_reg && !is_put) ? $signed(found_data_reg) : 32'sd0;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            valid_reg      <= '0;
            idx_reg        <= '0;
            pend_scan_reg  <= 1'b0;
            pend_sweep_reg <= 1'b0;
            pidx_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_capacity;
            end
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            pend_scan_reg  <= ctrl.scan_rd;
            pend_sweep_reg <= ctrl.sweep_rd;
            pidx_reg       <= idx_reg;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        used_reg       <= used_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_data_reg <= found_data_next;
        found_rank_reg <= found_rank_next;
        vic_ok_reg     <= vic_ok_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        free_ok_reg    <= free_ok_next;
        free_idx_reg   <= free_idx_next;
        slot_reg       <= slot_next;
        thr_reg        <= thr_next;
        inc_all_reg    <= inc_all_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/lfu_cache_table_unit.sv -----
// LFU key-value cache table with least-recently-used tie-break. Each request
// beat is a get or a put; every request returns exactly one response beat.
// One request is handled at a time. A request reads every table entry once
// from the entry RAM to find the key, a free slot and the eviction
// victim; a get hit or a put that changes the table then makes a second pass
// over the RAM to rewrite recency ranks and the touched entry. A request without
// the second pass (get miss, put with capacity zero) runs the scan and decision
// steps and then responds; with it, the rank-update pass comes between the
// decision and the response beat. Both RAM passes read one entry per cycle. No
// clearing pass after reset. Write capacity only while the block is idle.
// Depends on lfu_pkg, lfu_ctrl, lfu_datapath, lfu_ram.
module lfu_cache_table_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  lfu_pkg::lfu_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output lfu_pkg::lfu_rsp_t         rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_capacity
);
    import lfu_pkg::*;

    lfu_ctrl_t ctrl;
    lfu_stat_t stat;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lfu_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

endmodule

// ----- sim/lfu_cache_table_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for lfu_cache_table_unit: directed table, then random gets and puts
// over several capacity settings, checked against an in-bench LFU/LRU cache predictor.
// Depends on lfu_pkg and the lfu_cache_table_unit RTL.
module lfu_cache_table_unit_tb;
    import lfu_pkg::*;

    localparam int TABLE_SIZE = 16;
    localparam int KEY_POOL = 24;
    localparam int PHASE_ITEMS = 160;
    localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT = 800000;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        cmd;
        logic [31:0] key;
        logic [31:0] value;
        logic        typed;
        logic        exp_hit;
        logic [31:0] exp_value;
        logic [4:0]  cap;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    lfu_req_t         req = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    lfu_rsp_t         rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_capacity = '0;

    // predictor state
    logic             slot_valid [TABLE_SIZE];
    logic [31:0]      slot_key   [TABLE_SIZE];
    logic [31:0]      slot_data  [TABLE_SIZE];
    logic [31:0]      slot_uses  [TABLE_SIZE];
    int unsigned      slot_rank  [TABLE_SIZE];
    logic [CAP_W-1:0] cap_setting = CAP_RESET;

    lfu_rsp_t    awaited_rsp [$];
    plan_row_t   plan [0:21];
    logic [31:0] key_pool [KEY_POOL];
    logic [4:0]  phase_caps [0:9];

    int  mismatches = 0;
    int  requests_sent = 0;
    int  hits_seen = 0;
    int  cap_writes = 0;
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  hold_off_go = 1'b0;
    bit  hold_off_done = 1'b0;
    int  hold_left = 0;

    lfu_cache_table_unit #(.MAX_ENTRIES(TABLE_SIZE)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Move slot s to rank 0, pushing the newer entries down by one.
    function automatic void make_recent(int s);
        int unsigned r;
        r = slot_rank[s];
        for (int j = 0; j < TABLE_SIZE; j++)
            if (slot_valid[j] && j != s && slot_rank[j] < r)
                slot_rank[j]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void bump_use(int s);
        make_recent(s);
        if (slot_uses[s] != 32'hFFFF_FFFF)
            slot_uses[s]++;
    endfunction

    function automatic lfu_rsp_t cache_lookup(lfu_req_t beat);
        int          found;
        int          free_slot;
        int          victim;
        int unsigned used;
        int unsigned eff_cap;
        int unsigned vr;
        lfu_rsp_t    res;
        found = -1;
        free_slot = -1;
        victim = -1;
        used = 0;
        eff_cap = (cap_setting > TABLE_SIZE) ? TABLE_SIZE : cap_setting;
        for (int j = 0; j < TABLE_SIZE; j++)
        begin
            if (slot_valid[j])
            begin
                used++;
                if (found < 0 && slot_key[j] == 32'(beat.key))
                    found = j;
                // lowest count wins; on a tie, the oldest
                if (victim < 0 || slot_uses[j] < slot_uses[victim] ||
                    (slot_uses[j] == slot_uses[victim] && slot_rank[j] > slot_rank[victim]))
                    victim = j;
            end
            else if (free_slot < 0)
                free_slot = j;
        end
        res.hit = (found >= 0);
        res.read_value = '0;
        if (beat.cmd == CMD_GET)
        begin
            if (found >= 0)
            begin
                res.read_value = slot_data[found];
                bump_use(found);
            end
            return res;
        end
        if (eff_cap == 0)
            return res;
        if (found >= 0)
        begin
            slot_data[found] = beat.value;
            bump_use(found);
            return res;
        end
        if (used >= eff_cap || free_slot < 0)
        begin
            // evict and close the rank gap
            vr = slot_rank[victim];
            slot_valid[victim] = 1'b0;
            for (int j = 0; j < TABLE_SIZE; j++)
                if (slot_valid[j] && slot_rank[j] > vr)
                    slot_rank[j]--;
            free_slot = victim;
        end
        used = 0;
        for (int j = 0; j < TABLE_SIZE; j++)
            if (slot_valid[j])
                used++;
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = beat.key;
        slot_data[free_slot] = beat.value;
        slot_uses[free_slot] = 32'd1;
        slot_rank[free_slot] = used;
        make_recent(free_slot);
        return res;
    endfunction

    task automatic offer(input lfu_req_t beat, input bit typed, input lfu_rsp_t typed_rsp);
        lfu_rsp_t predicted;
        while (!calm && $urandom_range(99) < 20)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= beat;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = cache_lookup(beat);
        awaited_rsp.push_back(typed ? typed_rsp : predicted);
        requests_sent++;
    endtask

    // Write capacity only once the block has gone idle.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_setting = cap;
        cap_writes++;
    endtask

    // Response side: check each beat, then pick the next ready level.
    always @(posedge clk)
    begin
        lfu_rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("response beat with nothing expected: hit %0d read_value %h",
                       rsp.hit, rsp.read_value);
                mismatches++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.hit !== want.hit)
                begin
                    $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp.hit);
                    mismatches++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value mismatch: expected %h, actual %h",
                           want.read_value, rsp.read_value);
                    mismatches++;
                end
                if (rsp.hit === 1'b1)
                    hits_seen++;
            end
        end
        if (hold_off_go && !hold_off_done)
        begin
            hold_off_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= rst_n && (calm || $urandom_range(99) >= 20);
    end

    initial
    begin
        lfu_req_t  beat;
        lfu_rsp_t  typed_rsp;
        plan_row_t row;

        for (int j = 0; j < TABLE_SIZE; j++)
            slot_valid[j] = 1'b0;

        plan = '{
            '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF,
              5'd0},
            '{ROW_REQ, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 5'd0},
            '{ROW_REQ, CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF,
              5'd0},
            '{ROW_REQ, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
            // capacity zero: puts are dropped, gets still served
            '{ROW_CFG, CMD_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_PUT, 32'h0000_0005, 32'h0000_0001, 1'b1, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_PUT, 32'h8000_0000, 32'h0000_0003, 1'b1, 1'b1, 32'h0, 5'd0},
            '{ROW_REQ, CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF,
              5'd0},
            // capacity below occupancy
            '{ROW_CFG, CMD_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd1},
            '{ROW_REQ, CMD_PUT, 32'h0000_0009, 32'h0000_0009, 1'b0, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_PUT, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
            // capacity above table size saturates
            '{ROW_CFG, CMD_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd31},
            '{ROW_REQ, CMD_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, 32'h0, 5'd0},
            '{ROW_REQ, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
            '{ROW_CFG, CMD_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd16}
        };
        phase_caps = '{5'd16, 5'd3, 5'd0, 5'd1, 5'd31, 5'd8, 5'd2, 5'd17, 5'd12, 5'd16};

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int j = 4; j < KEY_POOL; j++)
            key_pool[j] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
                set_capacity(row.cap);
            else
            begin
                beat.cmd = row.cmd;
                beat.key = row.key;
                beat.value = row.value;
                typed_rsp.hit = row.exp_hit;
                typed_rsp.read_value = row.exp_value;
                offer(beat, row.typed, typed_rsp);
            end
        end

        for (int p = 0; p < 10; p++)
        begin
            set_capacity(phase_caps[p]);
            calm = (p == 6);
            if (p == 1)
                hold_off_go = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                beat.cmd = $urandom_range(1) ? CMD_PUT : CMD_GET;
                // skew toward the low pool entries so counts spread out
                if ($urandom_range(99) < 15)
                    beat.key = $urandom;
                else
                    beat.key = key_pool[$urandom_range(0, $urandom_range(0, KEY_POOL - 1))];
                beat.value = $urandom;
                typed_rsp = '0;
                offer(beat, 1'b0, typed_rsp);
            end
            calm = 1'b0;
        end

        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d get/put requests, %0d answered as hits, across %0d capacity writes",
                 requests_sent, hits_seen, cap_writes);
        $display("Settings included zero, one, values below occupancy and above table size");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
